// ----- sv/chmc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chmc_pkg: shared types and constants of the cache hit/miss classifier
// Geometry limits, register and code names, queue entry and set row layout.
// ----------------------------------------------------------------------------
package chmc_pkg;

   localparam int MAX_SETS  = 1024;
   localparam int MAX_WAYS  = 8;
   localparam int ADDR_BITS = 32;

   localparam int SET_BITS      = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
   localparam int WAY_BITS      = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int WCNT_BITS     = $clog2(MAX_WAYS + 1);
   localparam int IB_MAX        = $clog2(MAX_SETS + 1) - 1;
   localparam int LINE_CNT_BITS = $clog2(MAX_SETS * MAX_WAYS + 1);
   localparam int STAMP_BITS    = 64;
   localparam int USE_BITS      = 32;
   localparam int TOT_BITS      = 32;
   localparam int LFSR_BITS     = 32;
   localparam int DIGITS        = LFSR_BITS / 4;

   localparam logic [LFSR_BITS-1:0] LFSR_TOGGLE = 32'hB4BCD35C;

   // register indexes
   localparam logic [1:0] REG_OFFSET = 2'd0;
   localparam logic [1:0] REG_INDEX  = 2'd1;
   localparam logic [1:0] REG_WAYS   = 2'd2;
   localparam logic [1:0] REG_POLICY = 2'd3;

   // replacement policies
   localparam logic [1:0] POL_RANDOM = 2'd0;
   localparam logic [1:0] POL_FIFO   = 2'd1;
   localparam logic [1:0] POL_LRU    = 2'd2;
   localparam logic [1:0] POL_LFU    = 2'd3;

   // miss classes
   localparam logic [1:0] CLS_HIT        = 2'd0;
   localparam logic [1:0] CLS_COMPULSORY = 2'd1;
   localparam logic [1:0] CLS_CONFLICT   = 2'd2;
   localparam logic [1:0] CLS_CAPACITY   = 2'd3;

   typedef struct packed {
      logic [4:0]           offset_bits;
      logic [3:0]           ib;
      logic [WCNT_BITS-1:0] ways;
      logic [1:0]           policy;
   } cfg_type;

   typedef struct packed {
      logic [SET_BITS-1:0]  set;
      logic [ADDR_BITS-1:0] tag;
   } q_entry_type;

   typedef struct packed {
      logic [MAX_WAYS-1:0]                 valid;
      logic [MAX_WAYS-1:0][ADDR_BITS-1:0]  tag;
      logic [MAX_WAYS-1:0][STAMP_BITS-1:0] stamp;
      logic [MAX_WAYS-1:0][USE_BITS-1:0]   uses;
      logic [WAY_BITS-1:0]                 ptr;
   } row_type;

   localparam int ROW_BITS = $bits(row_type);

endpackage

// ----- sv/chmc_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chmc_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered and held between reads.
// ----------------------------------------------------------------------------
module chmc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/chmc_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chmc_front: address splitter
// Take one address, split it into set index and tag, hold it for the queue.
// ----------------------------------------------------------------------------
module chmc_front import chmc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  cfg_type              cfg,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [ADDR_BITS-1:0] req_address,
   output logic                 out_valid,
   input  logic                 out_ready,
   output q_entry_type          out_data
);

   logic                 valid_ff, valid_in;
   q_entry_type          data_ff;
   logic [ADDR_BITS-1:0] block;
   logic [SET_BITS:0]    set_mask;
   q_entry_type          split;

   assign req_ready = !valid_ff || out_ready;

   always_comb begin
      block     = req_address >> cfg.offset_bits;
      set_mask  = ((SET_BITS+1)'(1) << cfg.ib) - (SET_BITS+1)'(1);
      split.set = block[SET_BITS-1:0] & set_mask[SET_BITS-1:0];
      split.tag = block >> cfg.ib;
   end

   always_comb begin
      valid_in = valid_ff;
      if (out_ready) begin
         valid_in = 1'b0;
      end
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_valid && req_ready) begin
         data_ff <= split;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ----- sv/chmc_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chmc_queue: two-entry queue between front and back
// Decouple the address splitter from the tag engine.
// ----------------------------------------------------------------------------
module chmc_queue import chmc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push_valid,
   output logic        push_ready,
   input  q_entry_type push_data,
   output logic        pop_valid,
   input  logic        pop,
   output q_entry_type pop_data
);

   q_entry_type entry_ff [2];
   logic        wr_ptr_ff, rd_ptr_ff;
   logic [1:0]  count_ff;
   logic        do_push;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_ff + {1'b0, do_push} - {1'b0, pop};
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- sv/chmc_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chmc_back: tag engine
// Read one set row, compare tags, choose the victim, write the row back.
// ----------------------------------------------------------------------------
module chmc_back import chmc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  cfg_type              cfg,
   input  logic                 flush,
   input  logic                 q_valid,
   input  q_entry_type          q_data,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_is_hit,
   output logic [1:0]           rsp_miss_class,
   output logic [2:0]           rsp_victim_way,
   output logic [TOT_BITS-1:0]  rsp_hit_total,
   output logic [TOT_BITS-1:0]  rsp_miss_total,
   output logic [TOT_BITS-1:0]  rsp_compulsory_total,
   output logic [TOT_BITS-1:0]  rsp_conflict_total,
   output logic [TOT_BITS-1:0]  rsp_capacity_total
);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_EVAL  = 3'd2;
   localparam logic [2:0] ST_SCAN  = 3'd3;
   localparam logic [2:0] ST_FIN   = 3'd4;

   logic [2:0]               state_ff, state_in;
   logic [SET_BITS-1:0]      clr_ff, clr_in;
   logic [SET_BITS-1:0]      set_ff, set_in;
   logic [ADDR_BITS-1:0]     tag_ff, tag_in;
   logic                     fwd_ff, fwd_in;
   row_type                  wrow_ff, wrow_in;
   logic [WAY_BITS-1:0]      k_ff, k_in;
   logic [WAY_BITS-1:0]      best_ff, best_in;
   logic [LFSR_BITS-1:0]     lfsr_ff, lfsr_in;
   logic [STAMP_BITS-1:0]    time_ff, time_in;
   logic [LINE_CNT_BITS-1:0] vcnt_ff, vcnt_in;
   logic [TOT_BITS-1:0]      hits_ff, hits_in, miss_ff, miss_in;
   logic [TOT_BITS-1:0]      comp_ff, comp_in, conf_ff, conf_in, capa_ff, capa_in;
   logic                     rv_ff, rv_in;
   logic                     rhit_ff, rhit_in;
   logic [1:0]               rcls_ff, rcls_in;
   logic [2:0]               rway_ff, rway_in;

   row_type                  rd_row, row, new_row;
   logic                     ram_we, ram_re;
   logic [SET_BITS-1:0]      ram_waddr, ram_raddr;
   row_type                  ram_wdata;

   logic [MAX_WAYS-1:0]      match, empty;
   logic                     hit_any, free_any;
   logic [WAY_BITS-1:0]      hit_way, free_way;
   logic [WAY_BITS-1:0]      fifo_p, fifo_next;
   logic                     out_free, commit;
   logic [WAY_BITS-1:0]      c_way;
   logic                     less;
   logic [3:0]               digit;
   logic [WAY_BITS:0]        rem;
   logic [LINE_CNT_BITS-1:0] cap_lines;
   logic [LFSR_BITS-1:0]     lfsr_step;

   chmc_ram #(.WIDTH(ROW_BITS), .DEPTH(MAX_SETS)) u_rows (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (rd_row)
   );

   // take the row just written when the next item reads the same set
   assign row = fwd_ff ? wrow_ff : rd_row;

   always_comb begin
      hit_way  = '0;
      free_way = '0;
      for (int w = MAX_WAYS - 1; w >= 0; w--) begin
         match[w] = row.valid[w] && (row.tag[w] == tag_ff) &&
                    (WCNT_BITS'(w) < cfg.ways);
         empty[w] = !row.valid[w] && (WCNT_BITS'(w) < cfg.ways);
         if (match[w]) begin
            hit_way = WAY_BITS'(w);
         end
         if (empty[w]) begin
            free_way = WAY_BITS'(w);
         end
      end
      hit_any  = |match;
      free_any = |empty;
   end

   always_comb begin
      fifo_p = row.ptr;
      if ({1'b0, fifo_p} >= cfg.ways) begin
         fifo_p = '0;
      end
      fifo_next = fifo_p + WAY_BITS'(1);
      if (({1'b0, fifo_p} + WCNT_BITS'(1)) == cfg.ways) begin
         fifo_next = '0;
      end
   end

   // one compare per scan step; random victim reduces one nibble per step
   always_comb begin
      if (cfg.policy == POL_LRU) begin
         less = row.stamp[k_ff] < row.stamp[best_ff];
      end else begin
         less = row.uses[k_ff] < row.uses[best_ff];
      end
      digit = lfsr_ff[(DIGITS - 1 - int'(k_ff)) * 4 +: 4];
      rem   = {1'b0, best_ff};
      for (int b = 3; b >= 0; b--) begin
         rem = {rem[WAY_BITS-1:0], digit[b]};
         if (rem >= (WAY_BITS+1)'(cfg.ways)) begin
            rem = rem - (WAY_BITS+1)'(cfg.ways);
         end
      end
      lfsr_step = (lfsr_ff >> 1) ^ (lfsr_ff[0] ? LFSR_TOGGLE : '0);
   end

   assign cap_lines = LINE_CNT_BITS'(cfg.ways) << cfg.ib;
   assign out_free  = !rv_ff || rsp_ready;

   // updated row for a hit or a fill at c_way
   always_comb begin
      new_row = row;
      if (hit_any) begin
         new_row.stamp[c_way] = time_ff;
         new_row.uses[c_way]  = row.uses[c_way] + USE_BITS'(1);
      end else begin
         new_row.valid[c_way] = 1'b1;
         new_row.tag[c_way]   = tag_ff;
         new_row.stamp[c_way] = time_ff + STAMP_BITS'(1);
         new_row.uses[c_way]  = USE_BITS'(1);
         if (!free_any && cfg.policy == POL_FIFO) begin
            new_row.ptr = fifo_next;
         end
      end
   end

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      set_in    = set_ff;
      tag_in    = tag_ff;
      fwd_in    = fwd_ff;
      wrow_in   = wrow_ff;
      k_in      = k_ff;
      best_in   = best_ff;
      lfsr_in   = lfsr_ff;
      time_in   = time_ff;
      vcnt_in   = vcnt_ff;
      hits_in   = hits_ff;
      miss_in   = miss_ff;
      comp_in   = comp_ff;
      conf_in   = conf_ff;
      capa_in   = capa_ff;
      rv_in     = rv_ff && !rsp_ready;
      rhit_in   = rhit_ff;
      rcls_in   = rcls_ff;
      rway_in   = rway_ff;
      ram_we    = 1'b0;
      ram_waddr = set_ff;
      ram_wdata = new_row;
      ram_re    = 1'b0;
      ram_raddr = q_data.set;
      q_pop     = 1'b0;
      commit    = 1'b0;
      c_way     = best_ff;

      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
            clr_in    = clr_ff + SET_BITS'(1);
            if (clr_ff == SET_BITS'(MAX_SETS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               ram_re   = 1'b1;
               set_in   = q_data.set;
               tag_in   = q_data.tag;
               fwd_in   = 1'b0;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (hit_any) begin
               c_way  = hit_way;
               commit = out_free;
            end else if (free_any) begin
               c_way  = free_way;
               commit = out_free;
            end else if (cfg.policy == POL_FIFO) begin
               c_way  = fifo_p;
               commit = out_free;
            end else if (cfg.policy == POL_RANDOM) begin
               lfsr_in  = lfsr_step;
               k_in     = '0;
               best_in  = '0;
               state_in = ST_SCAN;
            end else if (cfg.ways == WCNT_BITS'(1)) begin
               c_way  = '0;
               commit = out_free;
            end else begin
               k_in     = WAY_BITS'(1);
               best_in  = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            k_in = k_ff + WAY_BITS'(1);
            if (cfg.policy == POL_RANDOM) begin
               best_in = rem[WAY_BITS-1:0];
               if (k_ff == WAY_BITS'(DIGITS - 1)) begin
                  state_in = ST_FIN;
               end
            end else begin
               if (less) begin
                  best_in = k_ff;
               end
               if (({1'b0, k_ff} + WCNT_BITS'(1)) == cfg.ways) begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_FIN: begin
            c_way  = best_ff;
            commit = out_free;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (commit) begin
         ram_we  = 1'b1;
         wrow_in = new_row;
         time_in = time_ff + STAMP_BITS'(1);
         rv_in   = 1'b1;
         rhit_in = hit_any;
         rway_in = 3'(c_way);
         if (hit_any) begin
            hits_in = hits_ff + TOT_BITS'(1);
            rcls_in = CLS_HIT;
         end else begin
            miss_in = miss_ff + TOT_BITS'(1);
            if (free_any) begin
               comp_in = comp_ff + TOT_BITS'(1);
               vcnt_in = vcnt_ff + LINE_CNT_BITS'(1);
               rcls_in = CLS_COMPULSORY;
            end else if (vcnt_ff >= cap_lines) begin
               capa_in = capa_ff + TOT_BITS'(1);
               rcls_in = CLS_CAPACITY;
            end else begin
               conf_in = conf_ff + TOT_BITS'(1);
               rcls_in = CLS_CONFLICT;
            end
         end
         // overlap the next set read with this write-back
         if (q_valid) begin
            q_pop    = 1'b1;
            ram_re   = 1'b1;
            set_in   = q_data.set;
            tag_in   = q_data.tag;
            fwd_in   = (q_data.set == set_ff);
            state_in = ST_EVAL;
         end else begin
            state_in = ST_IDLE;
         end
      end

      if (flush) begin
         state_in = ST_CLEAR;
         clr_in   = '0;
         vcnt_in  = '0;
         fwd_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         fwd_ff   <= 1'b0;
         k_ff     <= '0;
         best_ff  <= '0;
         lfsr_ff  <= LFSR_BITS'(1);
         time_ff  <= '0;
         vcnt_ff  <= '0;
         hits_ff  <= '0;
         miss_ff  <= '0;
         comp_ff  <= '0;
         conf_ff  <= '0;
         capa_ff  <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         fwd_ff   <= fwd_in;
         k_ff     <= k_in;
         best_ff  <= best_in;
         lfsr_ff  <= lfsr_in;
         time_ff  <= time_in;
         vcnt_ff  <= vcnt_in;
         hits_ff  <= hits_in;
         miss_ff  <= miss_in;
         comp_ff  <= comp_in;
         conf_ff  <= conf_in;
         capa_ff  <= capa_in;
         rv_ff    <= rv_in;
      end
      set_ff  <= set_in;
      tag_ff  <= tag_in;
      wrow_ff <= wrow_in;
      rhit_ff <= rhit_in;
      rcls_ff <= rcls_in;
      rway_ff <= rway_in;
   end

   assign rsp_valid            = rv_ff;
   assign rsp_is_hit           = rhit_ff;
   assign rsp_miss_class       = rcls_ff;
   assign rsp_victim_way       = rway_ff;
   assign rsp_hit_total        = hits_ff;
   assign rsp_miss_total       = miss_ff;
   assign rsp_compulsory_total = comp_ff;
   assign rsp_conflict_total   = conf_ff;
   assign rsp_capacity_total   = capa_ff;

endmodule

// ----- sv/cache_hit_miss_classifier.sv -----
`timescale 1ns / 1ps
// Throughput: one request per cycle at best; the write-back of one set row overlaps the
// registered read of the next, and a row just written is forwarded to a same-set request.
// Reset, and every write of offset_bits, index_bits or ways_used, starts a clearing pass
// over all 1024 rows of the row RAM; requests queue up but are not processed meanwhile.
// ----------------------------------------------------------------------------
// cache_hit_miss_classifier: set-associative tag store with miss classification
// Split each address, look up its set, classify hit or miss, pick a victim.
// ----------------------------------------------------------------------------
module cache_hit_miss_classifier import chmc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [ADDR_BITS-1:0] req_address,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_is_hit,
   output logic [1:0]           rsp_miss_class,
   output logic [2:0]           rsp_victim_way,
   output logic [TOT_BITS-1:0]  rsp_hit_total,
   output logic [TOT_BITS-1:0]  rsp_miss_total,
   output logic [TOT_BITS-1:0]  rsp_compulsory_total,
   output logic [TOT_BITS-1:0]  rsp_conflict_total,
   output logic [TOT_BITS-1:0]  rsp_capacity_total,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [1:0]           csr_index,
   input  logic [31:0]          csr_data
);

   logic [4:0]  offset_ff;
   logic [3:0]  index_ff;
   logic [3:0]  ways_ff;
   logic [1:0]  policy_ff;
   logic        csr_write;
   logic        flush;
   cfg_type     cfg;
   logic        fq_valid, fq_ready;
   q_entry_type fq_data;
   logic        qb_valid, qb_pop;
   q_entry_type qb_data;

   // configuration is always taken; any geometry write flushes the tag store
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign flush     = csr_write && (csr_index == REG_OFFSET || csr_index == REG_INDEX ||
                                    csr_index == REG_WAYS);

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= 5'd4;
         index_ff  <= 4'd8;
         ways_ff   <= 4'd1;
         policy_ff <= POL_LRU;
      end else if (csr_write) begin
         case (csr_index)
            REG_OFFSET: offset_ff <= csr_data[4:0];
            REG_INDEX:  index_ff  <= csr_data[3:0];
            REG_WAYS:   ways_ff   <= csr_data[3:0];
            REG_POLICY: policy_ff <= csr_data[1:0];
            default: begin
            end
         endcase
      end
   end

   // clamp geometry: zero ways acts as one, too many sets or ways saturate
   always_comb begin
      cfg.offset_bits = offset_ff;
      cfg.policy      = policy_ff;
      cfg.ib          = (index_ff > 4'(IB_MAX)) ? 4'(IB_MAX) : index_ff;
      if (ways_ff == 4'd0) begin
         cfg.ways = WCNT_BITS'(1);
      end else if (ways_ff > 4'(MAX_WAYS)) begin
         cfg.ways = WCNT_BITS'(MAX_WAYS);
      end else begin
         cfg.ways = WCNT_BITS'(ways_ff);
      end
   end

   chmc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_address (req_address),
      .out_valid   (fq_valid),
      .out_ready   (fq_ready),
      .out_data    (fq_data)
   );

   chmc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_data  (fq_data),
      .pop_valid  (qb_valid),
      .pop        (qb_pop),
      .pop_data   (qb_data)
   );

   chmc_back u_back (
      .clock                (clock),
      .reset                (reset),
      .cfg                  (cfg),
      .flush                (flush),
      .q_valid              (qb_valid),
      .q_data               (qb_data),
      .q_pop                (qb_pop),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_is_hit           (rsp_is_hit),
      .rsp_miss_class       (rsp_miss_class),
      .rsp_victim_way       (rsp_victim_way),
      .rsp_hit_total        (rsp_hit_total),
      .rsp_miss_total       (rsp_miss_total),
      .rsp_compulsory_total (rsp_compulsory_total),
      .rsp_conflict_total   (rsp_conflict_total),
      .rsp_capacity_total   (rsp_capacity_total)
   );

endmodule

// ----- sv/chmc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chmc_checker: port-level checks of the classifier
// Response consistency and totals bookkeeping, bound to the top level.
// ----------------------------------------------------------------------------
module chmc_checker import chmc_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic                rsp_is_hit,
   input logic [1:0]          rsp_miss_class,
   input logic [TOT_BITS-1:0] rsp_hit_total,
   input logic [TOT_BITS-1:0] rsp_miss_total,
   input logic [TOT_BITS-1:0] rsp_compulsory_total,
   input logic [TOT_BITS-1:0] rsp_conflict_total,
   input logic [TOT_BITS-1:0] rsp_capacity_total
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit_total) &&
                                  $stable(rsp_miss_total))
      else $error("response dropped or changed while stalled");

   a_hit_class: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_hit == (rsp_miss_class == CLS_HIT)))
      else $error("hit flag disagrees with miss class");

   a_miss_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_miss_total == TOT_BITS'(rsp_compulsory_total +
                                     rsp_conflict_total + rsp_capacity_total))
      else $error("miss total is not the sum of the classes");

   // a hit response that directly follows an accepted one must advance the count
   a_one_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready ##1 rsp_valid && rsp_is_hit |->
         rsp_hit_total != $past(rsp_hit_total))
      else $error("hit total did not advance");

endmodule

bind cache_hit_miss_classifier chmc_checker u_chmc_checker (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp_valid),
   .rsp_ready            (rsp_ready),
   .rsp_is_hit           (rsp_is_hit),
   .rsp_miss_class       (rsp_miss_class),
   .rsp_hit_total        (rsp_hit_total),
   .rsp_miss_total       (rsp_miss_total),
   .rsp_compulsory_total (rsp_compulsory_total),
   .rsp_conflict_total   (rsp_conflict_total),
   .rsp_capacity_total   (rsp_capacity_total)
);

// ----- bench/cache_hit_miss_classifier_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cache_hit_miss_classifier_tb: self-checking bench of the hit/miss classifier
// Sends addresses under several cache geometries and replacement policies.
// A behavioral tag store in the bench works out each classification, and
// every response is compared field by field against it, in order.
// ----------------------------------------------------------------------------
module cache_hit_miss_classifier_tb;
   import chmc_pkg::*;

   localparam int LINE_SLOTS  = MAX_SETS * MAX_WAYS;
   localparam int STALL_LIMIT = 5000;   // covers a clearing pass plus long stalls

   typedef struct packed {
      logic                is_hit;
      logic [1:0]          miss_class;
      logic [2:0]          victim_way;
      logic [TOT_BITS-1:0] hits;
      logic [TOT_BITS-1:0] misses;
      logic [TOT_BITS-1:0] compulsory;
      logic [TOT_BITS-1:0] conflicts;
      logic [TOT_BITS-1:0] capacity;
   } access_outcome_t;

   // block ports; the inputs driven by the bench are known from time zero
   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [ADDR_BITS-1:0] req_address = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_is_hit;
   logic [1:0]           rsp_miss_class;
   logic [2:0]           rsp_victim_way;
   logic [TOT_BITS-1:0]  rsp_hit_total, rsp_miss_total, rsp_compulsory_total;
   logic [TOT_BITS-1:0]  rsp_conflict_total, rsp_capacity_total;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [1:0]           csr_index = REG_OFFSET;
   logic [31:0]          csr_data = '0;

   // mirror of the tag store
   logic [4:0]           geo_offset;
   logic [3:0]           geo_index;
   logic [3:0]           geo_ways;
   logic [1:0]           repl_policy;
   bit                   mir_valid [LINE_SLOTS];
   logic [31:0]          mir_tag   [LINE_SLOTS];
   logic [63:0]          mir_stamp [LINE_SLOTS];
   logic [31:0]          mir_uses  [LINE_SLOTS];
   logic [2:0]           mir_fifo  [MAX_SETS];
   logic [63:0]          access_clock;
   int unsigned          filled_lines;
   logic [31:0]          victim_lfsr;
   logic [TOT_BITS-1:0]  tot_hit, tot_miss, tot_comp, tot_conf, tot_cap;

   access_outcome_t      pending_outcomes[$];
   int                   mismatch_count = 0;
   bit                   send_idles = 1'b1;
   bit                   rsp_stalls = 1'b1;
   int                   rsp_hold = 0;
   int                   quiet_cycles = 0;

   cache_hit_miss_classifier uut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Mirror maintenance
   // ------------------------------------------------------------------------
   function automatic void flush_mirror();
      for (int i = 0; i < LINE_SLOTS; i++) begin
         mir_valid[i] = 1'b0;
         mir_stamp[i] = '0;
         mir_uses[i]  = '0;
      end
      for (int s = 0; s < MAX_SETS; s++) mir_fifo[s] = '0;
      filled_lines = 0;
   endfunction

   function automatic void reset_mirror();
      geo_offset   = 5'd4;
      geo_index    = 4'd8;
      geo_ways     = 4'd1;
      repl_policy  = POL_LRU;
      access_clock = '0;
      victim_lfsr  = 32'd1;
      {tot_hit, tot_miss, tot_comp, tot_conf, tot_cap} = '0;
      flush_mirror();
   endfunction

   // Look up one address, update the mirror, return what the block must report.
   function automatic access_outcome_t classify_access(logic [31:0] addr);
      int unsigned     eff_ib, nways, sets, set_i, base, way;
      logic [31:0]     blk, tg;
      bit              found, free_way;
      access_outcome_t o;
      eff_ib = (geo_index > 4'd10) ? 10 : geo_index;
      nways  = (geo_ways == 0) ? 1 : ((geo_ways > 4'd8) ? 8 : geo_ways);
      sets   = 1 << eff_ib;
      blk    = addr >> geo_offset;
      set_i  = blk & (sets - 1);
      tg     = blk >> eff_ib;
      base   = set_i * MAX_WAYS;
      found  = 1'b0;
      free_way = 1'b0;
      way    = 0;
      o      = '0;
      for (int w = 0; w < nways; w++) begin
         if (!found && mir_valid[base+w] && mir_tag[base+w] == tg) begin
            found = 1'b1;
            way = w;
         end
      end
      if (found) begin
         o.is_hit = 1'b1;
         o.miss_class = CLS_HIT;
         mir_stamp[base+way] = access_clock;
         access_clock++;
         mir_uses[base+way]++;
         tot_hit++;
      end else begin
         tot_miss++;
         for (int w = 0; w < nways; w++) begin
            if (!free_way && !mir_valid[base+w]) begin
               free_way = 1'b1;
               way = w;
            end
         end
         if (free_way) begin
            o.miss_class = CLS_COMPULSORY;
            tot_comp++;
            filled_lines++;
         end else begin
            if (filled_lines >= sets * nways) begin
               o.miss_class = CLS_CAPACITY;
               tot_cap++;
            end else begin
               o.miss_class = CLS_CONFLICT;
               tot_conf++;
            end
            case (repl_policy)
               POL_RANDOM: begin
                  victim_lfsr = victim_lfsr[0] ? ((victim_lfsr >> 1) ^ LFSR_TOGGLE)
                                               : (victim_lfsr >> 1);
                  way = victim_lfsr % nways;
               end
               POL_FIFO: begin
                  way = (mir_fifo[set_i] >= nways) ? 0 : mir_fifo[set_i];
                  mir_fifo[set_i] = 3'((way + 1) % nways);
               end
               POL_LRU: begin
                  way = 0;
                  for (int w = 1; w < nways; w++)
                     if (mir_stamp[base+w] < mir_stamp[base+way]) way = w;
               end
               default: begin
                  way = 0;
                  for (int w = 1; w < nways; w++)
                     if (mir_uses[base+w] < mir_uses[base+way]) way = w;
               end
            endcase
         end
         mir_valid[base+way] = 1'b1;
         mir_tag[base+way]   = tg;
         access_clock++;
         mir_stamp[base+way] = access_clock;
         mir_uses[base+way]  = 32'd1;
      end
      o.victim_way = way[2:0];
      o.hits       = tot_hit;
      o.misses     = tot_miss;
      o.compulsory = tot_comp;
      o.conflicts  = tot_conf;
      o.capacity   = tot_cap;
      return o;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   // Mostly back-to-back or short pauses, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Send one request; valid stays high after acceptance so the next call
   // can follow back-to-back without dropping it.
   task automatic send_address(input logic [31:0] addr);
      int gap;
      gap = send_idles ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_address <= addr;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_outcomes.push_back(classify_access(addr));
   endtask

   // Drop valid and wait for every outstanding response.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic [1:0] idx, input logic [31:0] data);
      wait_drained();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         REG_OFFSET: begin geo_offset = data[4:0]; flush_mirror(); end
         REG_INDEX:  begin geo_index  = data[3:0]; flush_mirror(); end
         REG_WAYS:   begin geo_ways   = data[3:0]; flush_mirror(); end
         default:    repl_policy = data[1:0];
      endcase
   endtask

   task automatic set_geometry(input int ob, input int ib, input int nw, input int pol);
      write_register(REG_OFFSET, ob);
      write_register(REG_INDEX, ib);
      write_register(REG_WAYS, nw);
      write_register(REG_POLICY, pol);
   endtask

   // Build an address from a small tag pool so hits and evictions are common;
   // every so often use a fully random address to toggle every bit.
   function automatic logic [31:0] pooled_address(input int tag_pool, input int set_span);
      logic [63:0] a;
      int          eff_ib;
      if ($urandom_range(0, 9) == 0) return $urandom();
      eff_ib = (geo_index > 4'd10) ? 10 : geo_index;
      a = (64'($urandom_range(0, tag_pool)) << (geo_offset + eff_ib))
        | (64'($urandom_range(0, set_span)) << geo_offset)
        | (64'($urandom()) & ((64'd1 << geo_offset) - 1));
      return a[31:0];
   endfunction

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   // Reset geometry, then the corner geometries: one line, set conflicts,
   // clamped set and way counts, wide offsets, address extremes.
   task automatic test_directed();
      send_address(32'h0000_0000);      // compulsory under reset geometry
      send_address(32'h0000_0004);      // hit, same block
      send_address(32'hFFFF_FFFF);
      send_address(32'h0001_0000);      // same set as 0, evicts it (one way)
      // single line: second tag must be a capacity miss
      set_geometry(0, 0, 1, POL_LRU);
      send_address(32'h0000_0000);
      send_address(32'h0000_0001);
      send_address(32'h0000_0001);
      // two sets, one way: set 1 stays empty, so the eviction is a conflict
      write_register(REG_INDEX, 1);
      send_address(32'h0000_0000);
      send_address(32'h0000_0002);
      // ways of 0 acts as 1, ways of 15 acts as 8
      write_register(REG_WAYS, 0);
      send_address(32'h0000_0010);
      send_address(32'h0000_0012);
      write_register(REG_WAYS, 15);
      for (int t = 0; t < 9; t++) send_address(t << 1);
      // too many sets is clamped; wide offsets up to 31 are used as given
      set_geometry(16, 15, 2, POL_FIFO);
      send_address(32'hFFFF_FFFF);
      send_address(32'h8000_0000);
      write_register(REG_OFFSET, 31);
      send_address(32'h8000_0000);
      send_address(32'h7FFF_FFFF);
      send_address(32'h8000_0000);
      wait_drained();
   endtask

   // Each policy on a small cache with a small tag pool, so victims are chosen often.
   task automatic test_policies();
      for (int pol = POL_RANDOM; pol <= POL_LFU; pol++) begin
         set_geometry(2, 1, 4, pol);
         for (int n = 0; n < 120; n++) send_address(pooled_address(9, 1));
         if (pol == POL_FIFO) wait_drained();   // hold off until the pipe is empty
         // a second pass with more sets than the pool fills, for conflicts
         write_register(REG_INDEX, 2);
         for (int n = 0; n < 80; n++) send_address(pooled_address(7, 1));
      end
      wait_drained();
   endtask

   // Random settings, extremes included, with idling on and off both sides.
   task automatic test_random_settings();
      int ob, ib, nw;
      for (int ph = 0; ph < 12; ph++) begin
         case (ph)
            0:       begin ob = 0;  ib = 0;  nw = 8; end
            1:       begin ob = 16; ib = 10; nw = 8; end
            2:       begin ob = 31; ib = 0;  nw = 1; end
            default: begin
               ob = $urandom_range(0, 16);
               ib = $urandom_range(0, 4);
               nw = $urandom_range(0, 15);
            end
         endcase
         // junk in the upper data bits must be ignored
         write_register(REG_OFFSET, {27'($urandom_range(0, 32'h07FF_FFFF)), ob[4:0]});
         write_register(REG_INDEX, {28'($urandom_range(0, 32'h0FFF_FFFF)), ib[3:0]});
         write_register(REG_WAYS, {28'($urandom_range(0, 32'h0FFF_FFFF)), nw[3:0]});
         write_register(REG_POLICY, {30'($urandom()), 2'($urandom_range(0, 3))});
         send_idles = (ph % 4 != 1);
         rsp_stalls = (ph % 4 != 2);
         for (int n = 0; n < 80; n++)
            send_address(pooled_address(ph < 2 ? 63 : 15, ph < 2 ? 3 : 7));
      end
      send_idles = 1'b1;
      rsp_stalls = 1'b1;
      wait_drained();
   endtask

   // ------------------------------------------------------------------------
   // Response side: random back-pressure and in-order checking
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold <= rsp_hold - 1;
         rsp_ready <= 1'b0;
      end else if (rsp_stalls && $urandom_range(0, 9) < 3) begin
         rsp_hold <= pick_gap();
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      access_outcome_t want, got;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_is_hit, rsp_miss_class, rsp_victim_way, rsp_hit_total,
                 rsp_miss_total, rsp_compulsory_total, rsp_conflict_total,
                 rsp_capacity_total};
         if (pending_outcomes.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected response: %p", got);
         end else begin
            want = pending_outcomes.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("response mismatch\n  expected %p\n  actual   %p", want, got);
            end
         end
      end
   end

   // Watchdog: count cycles without any handshake.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
         $display("** cache_hit_miss_classifier: FAILED **");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      reset_mirror();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_policies();
      test_random_settings();
      repeat (30) @(posedge clock);
      if (mismatch_count == 0 && pending_outcomes.size() == 0)
         $display("** cache_hit_miss_classifier: PASSED **");
      else
         $display("** cache_hit_miss_classifier: FAILED **");
      $finish;
   end

endmodule
